FILE: design/pcps_pkg.sv
// Package for the packed column predicate scan: widths, register and mode codes,
// the configuration struct and the queue entry struct.
// No dependencies; every other file of the block imports it.
`default_nettype none

package pcps_pkg;

   // Field widths.
   localparam int PCPS_WORD_W    = 64;
   localparam int PCPS_TOTAL_W   = 19;
   localparam int PCPS_PRED_W    = 16;
   localparam int PCPS_LINES_W   = 5;
   localparam int PCPS_PAD_W     = 6;
   localparam int PCPS_MODE_W    = 3;
   localparam int PCPS_BYTE_LANES = 8;
   localparam int PCPS_HALF_LANES = 4;

   // Default segment limit for the running total.
   localparam int PCPS_MAX_SEGMENTS = 4096;

   // Configuration port.
   localparam int PCPS_ADDR_W = 5;
   localparam int PCPS_DATA_W = 32;

   // Queue between the front and the back.
   localparam int PCPS_QUEUE_DEPTH = 4;
   localparam int PCPS_QPTR_W      = $clog2(PCPS_QUEUE_DEPTH);

   // Register indexes.
   localparam logic [2:0] REG_COMPARE_MODE     = 3'd0;
   localparam logic [2:0] REG_LANE_WIDTH       = 3'd1;
   localparam logic [2:0] REG_FIRST_PREDICATE  = 3'd2;
   localparam logic [2:0] REG_SECOND_PREDICATE = 3'd3;
   localparam logic [2:0] REG_LINES_PER_SEG    = 3'd4;
   localparam logic [2:0] REG_PADDING_COUNT    = 3'd5;

   // Compare modes.
   localparam logic [PCPS_MODE_W-1:0] MODE_EQUAL       = 3'd0;
   localparam logic [PCPS_MODE_W-1:0] MODE_GREATER     = 3'd1;
   localparam logic [PCPS_MODE_W-1:0] MODE_LESS_EQUAL  = 3'd2;
   localparam logic [PCPS_MODE_W-1:0] MODE_RANGE       = 3'd3;
   localparam logic [PCPS_MODE_W-1:0] MODE_EQUAL_EITHER = 3'd4;

   // Lane width codes.
   localparam logic LANES_BYTE = 1'b0;
   localparam logic LANES_HALF = 1'b1;

   typedef struct packed {
      logic [PCPS_MODE_W-1:0]  compare_mode;
      logic                    lane_width;
      logic [PCPS_PRED_W-1:0]  first_predicate;
      logic [PCPS_PRED_W-1:0]  second_predicate;
      logic [PCPS_LINES_W-1:0] lines_per_segment;
      logic [PCPS_PAD_W-1:0]   padding_count;
   } pcps_cfg_type;

   // One classified word: its lane match bits and where it sits in the column.
   typedef struct packed {
      logic [PCPS_BYTE_LANES-1:0] lane_bits;
      logic                       last_word;
      logic                       segment_end;
   } pcps_entry_type;

endpackage

`default_nettype wire

FILE: design/pcps_req_if.sv
// Input channel of the predicate scan: one packed column word per item.
// Depends on pcps_pkg.
`default_nettype none

interface pcps_req_if;
   import pcps_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [PCPS_WORD_W-1:0] data_word;
   logic                   last_word;

   modport source (output valid, output data_word, output last_word, input ready);
   modport sink (input valid, input data_word, input last_word, output ready);
endinterface

`default_nettype wire

FILE: design/pcps_rsp_if.sv
// Result channel of the predicate scan: one segment mask per item.
// Depends on pcps_pkg.
`default_nettype none

interface pcps_rsp_if;
   import pcps_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [PCPS_WORD_W-1:0]  segment_mask;
   logic [PCPS_TOTAL_W-1:0] match_total;
   logic                    done_res;

   modport source (output valid, output segment_mask, output match_total,
                   output done_res, input ready);
   modport sink (input valid, input segment_mask, input match_total,
                 input done_res, output ready);
endinterface

`default_nettype wire

FILE: design/packed_column_predicate_scan_core.sv
// Top level of the packed column predicate scan: configuration registers,
// compare front, word queue and segment back. Depends on pcps_pkg and the channel interfaces.
//
//   Channel   Direction  Handshake               Payload
//   req_chan  in         valid/ready             data_word[63:0], last_word
//   rsp_chan  out        valid/ready             segment_mask[63:0], match_total[18:0], done_res
//   APB       in         psel/penable, pready=1  paddr[4:0], pwdata/prdata[31:0]
//
// One word is accepted per cycle while the queue is not full; its lanes are compared as it is accepted
// and written to the queue. The back then pops it from the queue, so a word that closes a segment
// has its mask written from the queue entry into the result register once that register is free.
// A four-entry queue parts the front from the back, so words that close no segment
// keep flowing while a finished mask waits on rsp_chan.ready.
// Synchronous active-high reset clears line count, accumulator, total and queue;
// registers return to mode equal, byte lanes, eight lines per segment.
`default_nettype none

module packed_column_predicate_scan_core #(
   parameter int MAX_SEGMENTS = pcps_pkg::PCPS_MAX_SEGMENTS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   pcps_req_if.sink                              req_chan,
   pcps_rsp_if.source                            rsp_chan,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [pcps_pkg::PCPS_ADDR_W-1:0] paddr,
   input  wire logic [pcps_pkg::PCPS_DATA_W-1:0] pwdata,
   output logic      [pcps_pkg::PCPS_DATA_W-1:0] prdata,
   output logic                                  pready
);
   import pcps_pkg::*;

   pcps_cfg_type   cfg;
   pcps_entry_type push_entry;
   pcps_entry_type pop_entry;
   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_empty;

   pcps_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pcps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   pcps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   pcps_back #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_chan    (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: design/pcps_regs.sv
// Configuration registers of the predicate scan behind an APB-style port.
// Depends on pcps_pkg.
`default_nettype none

module pcps_regs (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [pcps_pkg::PCPS_ADDR_W-1:0] paddr,
   input  wire logic [pcps_pkg::PCPS_DATA_W-1:0] pwdata,
   output logic      [pcps_pkg::PCPS_DATA_W-1:0] prdata,
   output logic                                 pready,
   output pcps_pkg::pcps_cfg_type               cfg
);
   import pcps_pkg::*;

   pcps_cfg_type cfg_ff;
   pcps_cfg_type cfg_in;
   logic [2:0]   reg_index;
   logic         write_en;

   assign reg_index = paddr[PCPS_ADDR_W-1:2];
   assign write_en  = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_COMPARE_MODE:     cfg_in.compare_mode      = pwdata[PCPS_MODE_W-1:0];
            REG_LANE_WIDTH:       cfg_in.lane_width        = pwdata[0];
            REG_FIRST_PREDICATE:  cfg_in.first_predicate   = pwdata[PCPS_PRED_W-1:0];
            REG_SECOND_PREDICATE: cfg_in.second_predicate  = pwdata[PCPS_PRED_W-1:0];
            REG_LINES_PER_SEG:    cfg_in.lines_per_segment = pwdata[PCPS_LINES_W-1:0];
            REG_PADDING_COUNT:    cfg_in.padding_count     = pwdata[PCPS_PAD_W-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.compare_mode      <= MODE_EQUAL;
         cfg_ff.lane_width        <= LANES_BYTE;
         cfg_ff.first_predicate   <= '0;
         cfg_ff.second_predicate  <= '0;
         cfg_ff.lines_per_segment <= PCPS_LINES_W'(8);
         cfg_ff.padding_count     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      case (reg_index)
         REG_COMPARE_MODE:     prdata = PCPS_DATA_W'(cfg_ff.compare_mode);
         REG_LANE_WIDTH:       prdata = PCPS_DATA_W'(cfg_ff.lane_width);
         REG_FIRST_PREDICATE:  prdata = PCPS_DATA_W'(cfg_ff.first_predicate);
         REG_SECOND_PREDICATE: prdata = PCPS_DATA_W'(cfg_ff.second_predicate);
         REG_LINES_PER_SEG:    prdata = PCPS_DATA_W'(cfg_ff.lines_per_segment);
         REG_PADDING_COUNT:    prdata = PCPS_DATA_W'(cfg_ff.padding_count);
         default:              prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: design/pcps_front.sv
// Front of the predicate scan: accepts column words, compares every lane and
// tracks segment boundaries. Depends on pcps_pkg and pcps_req_if.
`default_nettype none

module pcps_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pcps_pkg::pcps_cfg_type cfg,
   pcps_req_if.sink                    req_chan,
   input  wire logic                   queue_full,
   output logic                        push,
   output pcps_pkg::pcps_entry_type    push_entry
);
   import pcps_pkg::*;

   logic [PCPS_LINES_W-1:0]    line_ff;
   logic [PCPS_LINES_W-1:0]    line_in;
   logic [PCPS_LINES_W:0]      line_next;
   logic                       seg_end;
   logic [PCPS_BYTE_LANES-1:0] eq1;
   logic [PCPS_BYTE_LANES-1:0] eq2;
   logic [PCPS_BYTE_LANES-1:0] gt1;
   logic [PCPS_BYTE_LANES-1:0] gt2;
   logic [PCPS_BYTE_LANES-1:0] lane_bits;

   assign req_chan.ready = ~queue_full;
   assign push           = req_chan.valid & ~queue_full;

   // Per-lane compares; lane j sits at the j-th lane from the bottom of the word.
   always_comb begin
      eq1 = '0;
      eq2 = '0;
      gt1 = '0;
      gt2 = '0;
      if (cfg.lane_width == LANES_BYTE) begin
         for (int j = 0; j < PCPS_BYTE_LANES; j++) begin
            eq1[j] = req_chan.data_word[8*j +: 8] == cfg.first_predicate[7:0];
            eq2[j] = req_chan.data_word[8*j +: 8] == cfg.second_predicate[7:0];
            gt1[j] = req_chan.data_word[8*j +: 8] > cfg.first_predicate[7:0];
            gt2[j] = req_chan.data_word[8*j +: 8] > cfg.second_predicate[7:0];
         end
      end else begin
         for (int j = 0; j < PCPS_HALF_LANES; j++) begin
            eq1[j] = req_chan.data_word[16*j +: 16] == cfg.first_predicate;
            eq2[j] = req_chan.data_word[16*j +: 16] == cfg.second_predicate;
            gt1[j] = $signed(req_chan.data_word[16*j +: 16]) >
                     $signed(cfg.first_predicate);
            gt2[j] = $signed(req_chan.data_word[16*j +: 16]) >
                     $signed(cfg.second_predicate);
         end
      end
   end

   // Mode select; the less-or-equal mode is inverted at segment end in the back.
   always_comb begin
      case (cfg.compare_mode)
         MODE_EQUAL:        lane_bits = eq1;
         MODE_GREATER:      lane_bits = gt1;
         MODE_LESS_EQUAL:   lane_bits = gt1;
         MODE_RANGE:        lane_bits = gt1 & ~gt2;
         MODE_EQUAL_EITHER: lane_bits = eq1 | eq2;
         default:           lane_bits = '0;
      endcase
   end

   // Segment boundary: the segment closes on its last line or on the column's end.
   assign line_next = {1'b0, line_ff} + (PCPS_LINES_W+1)'(1);
   assign seg_end   = req_chan.last_word | (line_next >= {1'b0, cfg.lines_per_segment});
   assign line_in   = seg_end ? '0 : line_next[PCPS_LINES_W-1:0];

   assign push_entry.lane_bits   = lane_bits;
   assign push_entry.last_word   = req_chan.last_word;
   assign push_entry.segment_end = seg_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
      end else if (push) begin
         line_ff <= line_in;
      end
   end

   // The line count restarts after every word that closes the column.
   a_line_restart: assert property (@(posedge clock) disable iff (reset)
      (push && req_chan.last_word) |=> (line_ff == '0))
      else $error("line count not cleared after column end");

endmodule

`default_nettype wire

FILE: design/pcps_queue.sv
// Short queue of classified words between the front and the back.
// Depends on pcps_pkg.
`default_nettype none

module pcps_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire pcps_pkg::pcps_entry_type push_entry,
   input  wire logic                     pop,
   output pcps_pkg::pcps_entry_type      pop_entry,
   output logic                          full,
   output logic                          empty
);
   import pcps_pkg::*;

   pcps_entry_type          entries_ff [PCPS_QUEUE_DEPTH];
   logic [PCPS_QPTR_W-1:0]  wr_ptr_ff;
   logic [PCPS_QPTR_W-1:0]  rd_ptr_ff;
   logic [PCPS_QPTR_W:0]    count_ff;
   logic [PCPS_QPTR_W:0]    count_in;

   assign full      = count_ff == (PCPS_QPTR_W+1)'(PCPS_QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PCPS_QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PCPS_QPTR_W+1)'(1);
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PCPS_QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PCPS_QPTR_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from an empty queue");

endmodule

`default_nettype wire

FILE: design/pcps_back.sv
// Back of the predicate scan: shifts lane bits into the segment accumulator,
// emits segment masks and keeps the saturating match total. Depends on pcps_pkg.
`default_nettype none

module pcps_back #(
   parameter int MAX_SEGMENTS = pcps_pkg::PCPS_MAX_SEGMENTS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire pcps_pkg::pcps_cfg_type   cfg,
   input  wire logic                     queue_empty,
   input  wire pcps_pkg::pcps_entry_type pop_entry,
   output logic                          pop,
   pcps_rsp_if.source                    rsp_chan
);
   import pcps_pkg::*;

   localparam int TotalLimit = (MAX_SEGMENTS * 64 > (2**PCPS_TOTAL_W) - 1) ?
                               (2**PCPS_TOTAL_W) - 1 : MAX_SEGMENTS * 64;
   localparam logic [PCPS_TOTAL_W:0] TotalCap = (PCPS_TOTAL_W+1)'(TotalLimit);

   logic [PCPS_WORD_W-1:0]  acc_ff;
   logic [PCPS_WORD_W-1:0]  acc_in;
   logic [PCPS_WORD_W-1:0]  acc_shifted;
   logic [PCPS_TOTAL_W-1:0] total_ff;
   logic [PCPS_TOTAL_W-1:0] total_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [PCPS_WORD_W-1:0]  out_mask_ff;
   logic [PCPS_TOTAL_W-1:0] out_total_ff;
   logic                    out_done_ff;
   logic [PCPS_WORD_W-1:0]  seg_mask;
   logic [6:0]              ones;
   logic [PCPS_TOTAL_W:0]   sum;
   logic [PCPS_TOTAL_W-1:0] sat_sum;
   logic                    out_free;
   logic                    emit;

   function automatic logic [6:0] count_ones(input logic [PCPS_WORD_W-1:0] v);
      logic [3:0] part [8];
      logic [6:0] n;
      n = '0;
      for (int b = 0; b < 8; b++) begin
         part[b] = '0;
         for (int i = 0; i < 8; i++) begin
            part[b] = part[b] + 4'(v[8*b + i]);
         end
      end
      for (int b = 0; b < 8; b++) begin
         n = n + 7'(part[b]);
      end
      return n;
   endfunction

   // Items that close no segment never wait on the result register.
   assign out_free = ~out_valid_ff | rsp_chan.ready;
   assign pop      = ~queue_empty & (~pop_entry.segment_end | out_free);
   assign emit     = pop & pop_entry.segment_end;

   // Accumulator shift by the number of lanes in a word.
   assign acc_shifted = (cfg.lane_width == LANES_BYTE) ?
                        {acc_ff[PCPS_WORD_W-9:0], pop_entry.lane_bits} :
                        {acc_ff[PCPS_WORD_W-5:0], pop_entry.lane_bits[3:0]};

   // Segment mask: less-or-equal inverts, and clears padding on the column's end.
   always_comb begin
      seg_mask = acc_shifted;
      if (cfg.compare_mode == MODE_LESS_EQUAL) begin
         seg_mask = ~acc_shifted;
         if (pop_entry.last_word) begin
            seg_mask = seg_mask & ({PCPS_WORD_W{1'b1}} << cfg.padding_count);
         end
      end
   end

   assign ones    = count_ones(seg_mask);
   assign sum     = {1'b0, total_ff} + (PCPS_TOTAL_W+1)'(ones);
   assign sat_sum = (sum > TotalCap) ? TotalCap[PCPS_TOTAL_W-1:0] : sum[PCPS_TOTAL_W-1:0];

   always_comb begin
      acc_in   = acc_ff;
      total_in = total_ff;
      if (pop) begin
         acc_in = acc_shifted;
         if (pop_entry.segment_end) begin
            acc_in   = '0;
            total_in = pop_entry.last_word ? '0 : sat_sum;
         end
      end
   end

   assign out_valid_in = emit | (out_valid_ff & ~rsp_chan.ready);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (emit) begin
         out_mask_ff  <= seg_mask;
         out_total_ff <= sat_sum;
         out_done_ff  <= pop_entry.last_word;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.segment_mask = out_mask_ff;
   assign rsp_chan.match_total  = out_total_ff;
   assign rsp_chan.done_res     = out_done_ff;

   a_total_capped: assert property (@(posedge clock) disable iff (reset)
      {1'b0, total_ff} <= TotalCap)
      else $error("running total above its cap");

   a_column_restart: assert property (@(posedge clock) disable iff (reset)
      (emit && pop_entry.last_word) |=> (total_ff == '0 && acc_ff == '0))
      else $error("column state not cleared after final segment");

endmodule

`default_nettype wire

FILE: verif/tb_packed_column_predicate_scan_core.sv
`timescale 1ns / 1ps
// Self-checking bench for packed_column_predicate_scan_core: streams column words with random
// gaps and stalls, programs the registers over APB and checks every segment result against a
// local model or a typed-in value. Depends on pcps_pkg, pcps_req_if, pcps_rsp_if and the core RTL.

module tb_packed_column_predicate_scan_core;
   import pcps_pkg::*;

   localparam int CYCLE_LIMIT    = 600000;
   localparam int SETTLE_CYCLES  = 12;
   localparam int RANDOM_WORDS   = 920;
   localparam int TOTAL_CAP      = (PCPS_MAX_SEGMENTS * 64 > (1 << PCPS_TOTAL_W) - 1) ?
                                   (1 << PCPS_TOTAL_W) - 1 : PCPS_MAX_SEGMENTS * 64;

   // Compare mode codes the package leaves unnamed; they match nothing.
   localparam logic [PCPS_MODE_W-1:0] MODE_RSVD5 = 3'd5;
   localparam logic [PCPS_MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [PCPS_MODE_W-1:0] MODE_RSVD7 = 3'd7;

   typedef struct packed {
      logic [PCPS_WORD_W-1:0]  mask;
      logic [PCPS_TOTAL_W-1:0] total;
      logic                    done;
   } seg_result_t;

   // One directed item: the settings it runs under, the word, and a typed-in result if known.
   typedef struct packed {
      pcps_cfg_type            cfg;
      logic [PCPS_WORD_W-1:0]  word;
      logic                    last;
      logic                    known;
      logic [PCPS_WORD_W-1:0]  mask;
      logic [PCPS_TOTAL_W-1:0] total;
      logic                    done;
   } scan_row_t;

   localparam int DIRECTED_ROWS = 24;

   scan_row_t directed [DIRECTED_ROWS] = '{
      // Reset settings: a one-word column closes a short segment as it is.
      '{'{MODE_EQUAL, LANES_BYTE, 16'h0000, 16'h0000, 5'd8, 6'd0},
        64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_00FF, 19'd8, 1'b1},
      '{'{MODE_EQUAL, LANES_BYTE, 16'h0000, 16'h0000, 5'd8, 6'd0},
        64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h0, 19'd0, 1'b1},
      // Byte mode uses only the low predicate byte.
      '{'{MODE_EQUAL, LANES_BYTE, 16'hAB00, 16'h0000, 5'd1, 6'd0},
        64'h00FF_00FF_00FF_00FF, 1'b0, 1'b1, 64'h0000_0000_0000_00AA, 19'd4, 1'b0},
      '{'{MODE_EQUAL, LANES_BYTE, 16'hAB00, 16'h0000, 5'd1, 6'd0},
        64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_00FF, 19'd12, 1'b1},
      '{'{MODE_GREATER, LANES_BYTE, 16'h00FF, 16'h0000, 5'd1, 6'd0},
        64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h0, 19'd0, 1'b1},
      '{'{MODE_GREATER, LANES_BYTE, 16'hFF00, 16'h0000, 5'd1, 6'd0},
        64'h0101_0101_0101_0101, 1'b1, 1'b1, 64'h0000_0000_0000_00FF, 19'd8, 1'b1},
      // Less-or-equal inverts the whole accumulator; padding clears only the final segment.
      '{'{MODE_LESS_EQUAL, LANES_BYTE, 16'h00FF, 16'h0000, 5'd1, 6'd0},
        64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 19'd64, 1'b1},
      '{'{MODE_LESS_EQUAL, LANES_BYTE, 16'h00FF, 16'h0000, 5'd1, 6'd63},
        64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 19'd1, 1'b1},
      '{'{MODE_LESS_EQUAL, LANES_BYTE, 16'h00FF, 16'h0000, 5'd1, 6'd63},
        64'h0000_0000_0000_0000, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 19'd64, 1'b0},
      '{'{MODE_LESS_EQUAL, LANES_BYTE, 16'h00FF, 16'h0000, 5'd1, 6'd63},
        64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h8000_0000_0000_0000, 19'd65, 1'b1},
      // Signed halfword range at the extremes of the predicates.
      '{'{MODE_RANGE, LANES_HALF, 16'h8000, 16'h7FFF, 5'd1, 6'd0},
        64'h8000_7FFF_0000_FFFF, 1'b1, 1'b1, 64'h0000_0000_0000_0007, 19'd3, 1'b1},
      '{'{MODE_RANGE, LANES_HALF, 16'h7FFF, 16'h8000, 5'd1, 6'd0},
        64'h7FFF_8000_1234_FFFF, 1'b1, 1'b1, 64'h0, 19'd0, 1'b1},
      '{'{MODE_EQUAL_EITHER, LANES_HALF, 16'h8000, 16'h7FFF, 5'd1, 6'd0},
        64'h8000_7FFF_8000_0001, 1'b1, 1'b1, 64'h0000_0000_0000_000E, 19'd3, 1'b1},
      '{'{MODE_EQUAL_EITHER, LANES_BYTE, 16'h0012, 16'h00FE, 5'd1, 6'd0},
        64'h12FE_0000_12FE_FE00, 1'b1, 1'b1, 64'h0000_0000_0000_00CE, 19'd5, 1'b1},
      // Unused modes produce empty lane masks.
      '{'{MODE_RSVD5, LANES_BYTE, 16'h0000, 16'h0000, 5'd1, 6'd0},
        64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0, 19'd0, 1'b1},
      '{'{MODE_RSVD6, LANES_BYTE, 16'h0000, 16'h0000, 5'd1, 6'd0},
        64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0, 19'd0, 1'b1},
      '{'{MODE_RSVD7, LANES_HALF, 16'h0000, 16'h0000, 5'd1, 6'd0},
        64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0, 19'd0, 1'b1},
      '{'{MODE_EQUAL, LANES_HALF, 16'hFFFF, 16'h0000, 5'd1, 6'd0},
        64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'h0000_0000_0000_000F, 19'd4, 1'b1},
      '{'{MODE_GREATER, LANES_HALF, 16'h7FFF, 16'h0000, 5'd1, 6'd0},
        64'h7FFF_7FFF_7FFF_7FFF, 1'b1, 1'b1, 64'h0, 19'd0, 1'b1},
      // A line count of zero behaves as one.
      '{'{MODE_EQUAL, LANES_BYTE, 16'h0000, 16'h0000, 5'd0, 6'd0},
        64'h0000_0000_0000_0000, 1'b0, 1'b1, 64'h0000_0000_0000_00FF, 19'd8, 1'b0},
      '{'{MODE_EQUAL, LANES_BYTE, 16'h0000, 16'h0000, 5'd0, 6'd0},
        64'h0000_0000_0000_0000, 1'b1, 1'b1, 64'h0000_0000_0000_00FF, 19'd16, 1'b1},
      // Sixteen-line halfword segment cut short by the last word.
      '{'{MODE_GREATER, LANES_HALF, 16'hFFFF, 16'h0000, 5'd16, 6'd0},
        64'h0000_FFFF_8000_7FFF, 1'b0, 1'b0, 64'h0, 19'd0, 1'b0},
      '{'{MODE_GREATER, LANES_HALF, 16'hFFFF, 16'h0000, 5'd16, 6'd0},
        64'h1234_5678_9ABC_DEF0, 1'b0, 1'b0, 64'h0, 19'd0, 1'b0},
      '{'{MODE_GREATER, LANES_HALF, 16'hFFFF, 16'h0000, 5'd16, 6'd0},
        64'h8001_0001_FFFE_0000, 1'b1, 1'b0, 64'h0, 19'd0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   logic                   psel;
   logic                   penable;
   logic                   pwrite;
   logic [PCPS_ADDR_W-1:0] paddr;
   logic [PCPS_DATA_W-1:0] pwdata;
   logic [PCPS_DATA_W-1:0] prdata;
   logic                   pready;

   pcps_req_if req_bus ();
   pcps_rsp_if rsp_bus ();

   packed_column_predicate_scan_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Register settings as the block holds them, and the segment state of the scan.
   pcps_cfg_type            csr_shadow;
   logic [PCPS_WORD_W-1:0]  scan_acc;
   logic [PCPS_LINES_W-1:0] scan_line;
   logic [PCPS_TOTAL_W-1:0] scan_total;

   seg_result_t pending_segments [$];

   bit quiet;
   int err_count;
   int words_sent;
   int csr_writes;
   int segments_seen;
   int columns_seen;
   int cycle_count;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
         $display("packed_column_predicate_scan_core regression: fail");
         $finish;
      end
   end

   // Short gaps are common, long ones rare.
   function automatic int pause_len();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // One match bit per lane under the current lane width, first lane highest.
   function automatic logic [7:0] lane_hits(input logic [63:0] w, input logic [15:0] pred,
                                            input bit greater);
      logic [7:0]         hits;
      logic [7:0]         b;
      logic signed [15:0] h;
      logic signed [15:0] p;
      hits = '0;
      p = pred;
      if (csr_shadow.lane_width == LANES_BYTE) begin
         for (int k = 0; k < PCPS_BYTE_LANES; k++) begin
            b = w[63 - 8*k -: 8];
            hits[7 - k] = greater ? (b > pred[7:0]) : (b == pred[7:0]);
         end
      end else begin
         for (int k = 0; k < PCPS_HALF_LANES; k++) begin
            h = w[63 - 16*k -: 16];
            hits[3 - k] = greater ? (h > p) : (h == p);
         end
      end
      return hits;
   endfunction

   // Folds one word into the segment; returns 1 with the result when the segment closes.
   function automatic bit fold_word(input logic [63:0] w, input logic last,
                                    output seg_result_t res);
      logic [7:0]  hits;
      logic [63:0] mask;
      int unsigned sum;
      res = '0;
      case (csr_shadow.compare_mode)
         MODE_EQUAL: hits = lane_hits(w, csr_shadow.first_predicate, 1'b0);
         MODE_GREATER, MODE_LESS_EQUAL: hits = lane_hits(w, csr_shadow.first_predicate, 1'b1);
         MODE_RANGE: hits = lane_hits(w, csr_shadow.first_predicate, 1'b1) &
                            ~lane_hits(w, csr_shadow.second_predicate, 1'b1);
         MODE_EQUAL_EITHER: hits = lane_hits(w, csr_shadow.first_predicate, 1'b0) |
                                   lane_hits(w, csr_shadow.second_predicate, 1'b0);
         default: hits = '0;
      endcase
      if (csr_shadow.lane_width == LANES_BYTE) begin
         scan_acc = (scan_acc << PCPS_BYTE_LANES) | 64'(hits);
      end else begin
         scan_acc = (scan_acc << PCPS_HALF_LANES) | 64'(hits[3:0]);
      end
      if (!last && int'(scan_line) + 1 < int'(csr_shadow.lines_per_segment)) begin
         scan_line = scan_line + 1'b1;
         return 1'b0;
      end
      mask = scan_acc;
      if (csr_shadow.compare_mode == MODE_LESS_EQUAL) begin
         mask = ~mask;
         if (last) mask &= ~64'd0 << csr_shadow.padding_count;
      end
      sum = scan_total + $countones(mask);
      if (sum > TOTAL_CAP) sum = TOTAL_CAP;
      res.mask = mask;
      res.total = PCPS_TOTAL_W'(sum);
      res.done = last;
      scan_acc = '0;
      scan_line = '0;
      scan_total = last ? '0 : PCPS_TOTAL_W'(sum);
      return 1'b1;
   endfunction

   function automatic logic [31:0] csr_value(input logic [2:0] idx, input pcps_cfg_type c);
      case (idx)
         REG_COMPARE_MODE:     return 32'(c.compare_mode);
         REG_LANE_WIDTH:       return 32'(c.lane_width);
         REG_FIRST_PREDICATE:  return 32'(c.first_predicate);
         REG_SECOND_PREDICATE: return 32'(c.second_predicate);
         REG_LINES_PER_SEG:    return 32'(c.lines_per_segment);
         default:              return 32'(c.padding_count);
      endcase
   endfunction

   function automatic logic [15:0] pick_predicate();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         4: return 16'h007F;
         5: return 16'h0080;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic pcps_cfg_type random_cfg();
      pcps_cfg_type c;
      int r;
      if ($urandom_range(4) == 0) c.compare_mode = PCPS_MODE_W'($urandom_range(MODE_RSVD7));
      else c.compare_mode = PCPS_MODE_W'($urandom_range(MODE_EQUAL_EITHER));
      c.lane_width = 1'($urandom_range(1));
      c.first_predicate = pick_predicate();
      c.second_predicate = pick_predicate();
      r = $urandom_range(99);
      if (r < 5) c.lines_per_segment = '0;
      else if (r < 70) c.lines_per_segment = PCPS_LINES_W'($urandom_range(1, 8));
      else if (r < 88) c.lines_per_segment = PCPS_LINES_W'($urandom_range(9, 16));
      else c.lines_per_segment = PCPS_LINES_W'($urandom_range(17, 31));
      r = $urandom_range(99);
      if (r < 20) c.padding_count = '0;
      else if (r < 35) c.padding_count = '1;
      else c.padding_count = PCPS_PAD_W'($urandom_range(63));
      return c;
   endfunction

   // Lane values sit mostly on or next to the predicates so every compare flips both ways.
   function automatic logic [15:0] near_value();
      case ($urandom_range(5))
         0: return csr_shadow.first_predicate;
         1: return csr_shadow.second_predicate;
         2: return csr_shadow.first_predicate + 16'd1;
         3: return csr_shadow.first_predicate - 16'd1;
         4: return csr_shadow.second_predicate + 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] make_word();
      logic [63:0] w;
      logic [15:0] v;
      w = {$urandom, $urandom};
      if ($urandom_range(6) == 0) return w;
      if (csr_shadow.lane_width == LANES_BYTE) begin
         for (int k = 0; k < PCPS_BYTE_LANES; k++) begin
            v = near_value();
            w[8*k +: 8] = v[7:0];
         end
      end else begin
         for (int k = 0; k < PCPS_HALF_LANES; k++) w[16*k +: 16] = near_value();
      end
      return w;
   endfunction

   // Column length: a few full segments and a partial one, shorter when lines are many.
   function automatic int column_length();
      int span;
      span = (csr_shadow.lines_per_segment == 0) ? 1 : int'(csr_shadow.lines_per_segment);
      if (span > 16) return $urandom_range(0, 1) * span + $urandom_range(1, span);
      return $urandom_range(0, 3) * span + $urandom_range(1, span);
   endfunction

   // Offers one item after a random gap, none in quiet phases, and records the result it should cause.
   task automatic send_word(input logic [63:0] w, input logic last, input logic use_typed,
                            input seg_result_t typed);
      seg_result_t predicted;
      int gap;
      gap = quiet ? 0 : pause_len();
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         req_bus.data_word <= {$urandom, $urandom};
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.data_word <= w;
      req_bus.last_word <= last;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
      if (fold_word(w, last, predicted)) begin
         pending_segments.push_back(use_typed ? typed : predicted);
      end
   endtask

   // Stops offering items and waits for every pending result, optionally plus pipeline tail.
   task automatic settle(input bit with_tail);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
      if (with_tail) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write followed by a read back of the same register.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] seen;
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PCPS_ADDR_W'({idx, 2'b00});
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      csr_writes++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      seen = prdata;
      if (seen != value) begin
         $display("%0t: register %0d read back expected %h, got %h", $time, idx, value, seen);
         err_count++;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Writes the registers that change, only once the block has gone idle.
   task automatic program_csr(input pcps_cfg_type next);
      bit differs;
      differs = 1'b0;
      for (int i = REG_COMPARE_MODE; i <= REG_PADDING_COUNT; i++) begin
         if (csr_value(3'(i), next) != csr_value(3'(i), csr_shadow)) differs = 1'b1;
      end
      if (differs) begin
         settle(1'b1);
         for (int i = REG_COMPARE_MODE; i <= REG_PADDING_COUNT; i++) begin
            if (csr_value(3'(i), next) != csr_value(3'(i), csr_shadow)) begin
               csr_write(3'(i), csr_value(3'(i), next));
            end
         end
         csr_shadow = next;
      end
   endtask

   // Result side: ready drops for random stretches except in quiet phases.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!quiet && $urandom_range(99) < 25) stall_left = pause_len();
         end
      end
   end

   // Every accepted result is matched against the oldest expected segment.
   always @(posedge clock) begin
      seg_result_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_segments.size() == 0) begin
            $display("%0t: unexpected result, mask %h total %0d done %0b", $time,
                     rsp_bus.segment_mask, rsp_bus.match_total, rsp_bus.done_res);
            err_count++;
         end else begin
            want = pending_segments.pop_front();
            segments_seen++;
            if (want.done) columns_seen++;
            if (rsp_bus.segment_mask !== want.mask) begin
               $display("%0t: segment_mask expected %h, got %h", $time, want.mask,
                        rsp_bus.segment_mask);
               err_count++;
            end
            if (rsp_bus.match_total !== want.total) begin
               $display("%0t: match_total expected %0d, got %0d", $time, want.total,
                        rsp_bus.match_total);
               err_count++;
            end
            if (rsp_bus.done_res !== want.done) begin
               $display("%0t: done_res expected %0b, got %0b", $time, want.done,
                        rsp_bus.done_res);
               err_count++;
            end
         end
      end
   end

   initial begin
      seg_result_t typed;
      int random_goal;
      int columns;
      int span;
      bit open_end;
      bit held_once;

      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.data_word = '0;
      req_bus.last_word = 1'b0;
      quiet = 1'b0;
      held_once = 1'b0;
      csr_shadow = '{MODE_EQUAL, LANES_BYTE, 16'h0000, 16'h0000, 5'd8, 6'd0};
      scan_acc = '0;
      scan_line = '0;
      scan_total = '0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         program_csr(directed[i].cfg);
         typed = '{directed[i].mask, directed[i].total, directed[i].done};
         send_word(directed[i].word, directed[i].last, directed[i].known, typed);
      end

      // Random phases: new settings, then a few columns; some phases leave a column open.
      random_goal = words_sent + RANDOM_WORDS;
      while (words_sent < random_goal) begin
         program_csr(random_cfg());
         quiet = ($urandom_range(7) == 0);
         columns = $urandom_range(1, 3);
         for (int c = 0; c < columns; c++) begin
            span = column_length();
            open_end = (c == columns - 1) && ($urandom_range(4) == 0);
            for (int w = 0; w < span; w++) begin
               if (pending_segments.size() != 0 && (!held_once || $urandom_range(39) == 0)) begin
                  settle(1'b0);
                  held_once = 1'b1;
               end
               send_word(make_word(), (w == span - 1) && !open_end, 1'b0, '0);
            end
         end
      end

      settle(1'b1);
      $display("Scanned %0d column words under %0d register writes, all modes and lane widths.",
               words_sent, csr_writes);
      $display("Checked %0d segment masks over %0d column ends with random gaps and stalls.",
               segments_seen, columns_seen);
      if (err_count == 0) begin
         $display("packed_column_predicate_scan_core regression: pass");
      end else begin
         $display("packed_column_predicate_scan_core regression: fail");
      end
      $finish;
   end

endmodule
